/* src/rc4x_pkg.sv */
// Shared types and constants for the RC4-style keystream XOR block.
`default_nettype none

package rc4x_pkg;

   localparam int IDX_W      = 8;
   localparam int PERM_DEPTH = 256;
   localparam int KEY_W      = 64;
   localparam int KEY_IDX_W  = $clog2(KEY_W);

   // one access slot to the permutation memory
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [IDX_W-1:0] wdata;
      logic [IDX_W-1:0] raddr;
   } ram_req_type;

endpackage

`default_nettype wire

/* src/rc4x_perm_ram.sv */
// Permutation store: 256 x 8, one write and one registered read per cycle.
`default_nettype none

module rc4x_perm_ram (
   input  wire logic                         clock,
   input  wire rc4x_pkg::ram_req_type        ram_req,
   output logic [rc4x_pkg::IDX_W-1:0]        rdata
);

   logic [rc4x_pkg::IDX_W-1:0] perm_mem_ff [rc4x_pkg::PERM_DEPTH];
   logic [rc4x_pkg::IDX_W-1:0] rdata_ff;

   // read-first: a read at the address being written returns the old entry
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         perm_mem_ff[ram_req.waddr] <= ram_req.wdata;
      end
      rdata_ff <= perm_mem_ff[ram_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* src/rc4x_core.sv */
// Sequencer and shared 8-bit index adder for key schedule and byte generation.
`default_nettype none

module rc4x_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic                           item_last,
   input  wire logic [rc4x_pkg::KEY_W-1:0]     key,
   input  wire logic                           out_free,
   output rc4x_pkg::ram_req_type               ram_req,
   input  wire logic [rc4x_pkg::IDX_W-1:0]     rdata,
   output logic                                idle,
   output logic                                done,
   output logic [rc4x_pkg::IDX_W-1:0]          ks
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FILL  = 4'd1;
   localparam logic [3:0] ST_K_RDN = 4'd2;
   localparam logic [3:0] ST_K_RDJ = 4'd3;
   localparam logic [3:0] ST_K_WRN = 4'd4;
   localparam logic [3:0] ST_K_WRJ = 4'd5;
   localparam logic [3:0] ST_G_RDI = 4'd6;
   localparam logic [3:0] ST_G_RDJ = 4'd7;
   localparam logic [3:0] ST_G_WRI = 4'd8;
   localparam logic [3:0] ST_G_WRJ = 4'd9;
   localparam logic [3:0] ST_G_KS  = 4'd10;

   localparam logic [rc4x_pkg::IDX_W-1:0] LAST_IDX =
      rc4x_pkg::IDX_W'(rc4x_pkg::PERM_DEPTH - 1);

   logic [3:0]                 state_ff, state_in;
   logic                       need_sched_ff, need_sched_in;
   logic [rc4x_pkg::IDX_W-1:0] i_ff, i_in;
   logic [rc4x_pkg::IDX_W-1:0] j_ff, j_in;
   logic [rc4x_pkg::IDX_W-1:0] n_ff, n_in;
   logic [rc4x_pkg::IDX_W-1:0] si_ff, si_in;
   logic [rc4x_pkg::IDX_W-1:0] sj_ff, sj_in;
   logic [rc4x_pkg::IDX_W-1:0] r_ff, r_in;
   logic                       hit_ff, hit_in;

   // shared adder: sum = a + b + c, mod 256
   logic [rc4x_pkg::IDX_W-1:0] add_a, add_b, add_sum;
   logic                       add_c;
   logic                       kbit;

   assign add_sum = add_a + add_b + rc4x_pkg::IDX_W'(add_c);
   assign kbit    = key[n_ff[rc4x_pkg::KEY_IDX_W-1:0]];

   always_comb begin
      state_in      = state_ff;
      need_sched_in = need_sched_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      si_in         = si_ff;
      sj_in         = sj_ff;
      r_in          = r_ff;
      hit_in        = hit_ff;
      add_a         = '0;
      add_b         = '0;
      add_c         = 1'b0;
      ram_req       = '0;
      done          = 1'b0;
      ks            = hit_ff ? si_ff : rdata;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (need_sched_ff) begin
                  n_in     = '0;
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_G_RDI;
               end
            end
         end
         ST_FILL: begin
            // identity fill, one entry a cycle
            ram_req.we    = 1'b1;
            ram_req.waddr = n_ff;
            ram_req.wdata = n_ff;
            add_a         = n_ff;
            add_c         = 1'b1;
            n_in          = add_sum;
            if (n_ff == LAST_IDX) begin
               j_in     = '0;
               state_in = ST_K_RDN;
            end
         end
         ST_K_RDN: begin
            ram_req.raddr = n_ff;
            state_in      = ST_K_RDJ;
         end
         ST_K_RDJ: begin
            si_in         = rdata;
            add_a         = j_ff;
            add_b         = rdata;
            add_c         = kbit;
            j_in          = add_sum;
            ram_req.raddr = add_sum;
            state_in      = ST_K_WRN;
         end
         ST_K_WRN: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = n_ff;
            ram_req.wdata = rdata;
            state_in      = ST_K_WRJ;
         end
         ST_K_WRJ: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = j_ff;
            ram_req.wdata = si_ff;
            add_a         = n_ff;
            add_c         = 1'b1;
            n_in          = add_sum;
            if (n_ff == LAST_IDX) begin
               i_in          = '0;
               j_in          = '0;
               need_sched_in = 1'b0;
               state_in      = ST_G_RDI;
            end else begin
               state_in = ST_K_RDN;
            end
         end
         ST_G_RDI: begin
            add_a         = i_ff;
            add_c         = 1'b1;
            i_in          = add_sum;
            ram_req.raddr = add_sum;
            state_in      = ST_G_RDJ;
         end
         ST_G_RDJ: begin
            si_in         = rdata;
            add_a         = j_ff;
            add_b         = rdata;
            j_in          = add_sum;
            ram_req.raddr = add_sum;
            state_in      = ST_G_WRI;
         end
         ST_G_WRI: begin
            sj_in         = rdata;
            ram_req.we    = 1'b1;
            ram_req.waddr = i_ff;
            ram_req.wdata = rdata;
            state_in      = ST_G_WRJ;
         end
         ST_G_WRJ: begin
            // swap completes while S[r] is read; r == j hits the old value
            ram_req.we    = 1'b1;
            ram_req.waddr = j_ff;
            ram_req.wdata = si_ff;
            add_a         = si_ff;
            add_b         = sj_ff;
            r_in          = add_sum;
            hit_in        = (add_sum == j_ff);
            ram_req.raddr = add_sum;
            state_in      = ST_G_KS;
         end
         ST_G_KS: begin
            ram_req.raddr = r_ff;
            if (out_free) begin
               done = 1'b1;
               if (item_last) begin
                  need_sched_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         need_sched_ff <= 1'b1;
         i_ff          <= '0;
         j_ff          <= '0;
         n_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         need_sched_ff <= need_sched_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         n_ff          <= n_in;
      end
      si_ff  <= si_in;
      sj_ff  <= sj_in;
      r_ff   <= r_in;
      hit_ff <= hit_in;
   end

   assign idle = (state_ff == ST_IDLE);

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_req.we)
      else $error("permutation written while idle");

   a_sched_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_K_WRJ && n_ff == LAST_IDX)
      |=> (i_ff == '0 && j_ff == '0 && !need_sched_ff && state_ff == ST_G_RDI))
      else $error("indices not cleared after schedule");

   a_sched_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && need_sched_ff)
      |=> (state_ff == ST_FILL && n_ff == '0))
      else $error("new message did not start a schedule");

   a_last_rearm: assert property (@(posedge clock) disable iff (reset)
      (done && item_last) |=> need_sched_ff)
      else $error("last byte did not rearm schedule");

endmodule

`default_nettype wire

/* src/rc4_keystream_xor_unit.sv */
// Top level of the RC4-style keystream XOR unit.
// Usage notes:
//  - req_*: one transaction carries a data byte and a last-byte flag.
//    req_ready is high only while the sequencer is idle.
//  - rsp_*: one transaction per request, out_byte = data ^ keystream,
//    out_last copied from the request. Result held in an output register.
//  - csr_*: 64-bit key, read at each step of the key schedule, which runs on
//    the first byte of a message; a write during a schedule affects its rest.
//  - Byte within a message: the steps share the single permutation memory
//    port (read S[i], read S[j], two swap writes, read S[r]); the next request
//    is taken only once the sequencer is back to idle.
//  - First byte of a message: the key schedule runs first (identity fill of
//    all 256 entries, then 256 swap steps).
//  - Reset: key cleared, indices zero, schedule pending for the first byte.
//  - Receiver stall: a new request is still taken while a result waits;
//    the sequencer holds in its final step until the output register frees.
`default_nettype none

module rc4_keystream_xor_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_data_byte,
   input  wire logic                        req_last_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_out_last,
   input  wire logic                        csr_write_enable,
   input  wire logic [rc4x_pkg::KEY_W-1:0]  csr_write_data
);

   logic [rc4x_pkg::KEY_W-1:0] key_ff;
   logic [7:0]                 data_ff;
   logic                       last_ff;
   logic                       rsp_valid_ff;
   logic [7:0]                 rsp_byte_ff;
   logic                       rsp_last_ff;

   rc4x_pkg::ram_req_type      ram_req;
   logic [rc4x_pkg::IDX_W-1:0] ram_rdata;
   logic                       core_idle;
   logic                       core_done;
   logic [rc4x_pkg::IDX_W-1:0] core_ks;
   logic                       req_take;
   logic                       out_free;

   assign req_ready = core_idle;
   assign req_take  = req_valid && core_idle;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // key register
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write_enable) begin
         key_ff <= csr_write_data;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (core_done) begin
         rsp_byte_ff <= data_ff ^ core_ks;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

   rc4x_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (req_take),
      .item_last (last_ff),
      .key       (key_ff),
      .out_free  (out_free),
      .ram_req   (ram_req),
      .rdata     (ram_rdata),
      .idle      (core_idle),
      .done      (core_done),
      .ks        (core_ks)
   );

   rc4x_perm_ram u_perm_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (ram_rdata)
   );

endmodule

`default_nettype wire
